/* src/dtq_pkg.sv */
package dtq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_OUT = 16;
  localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_NEGATIVE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_BEST,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic add;
    logic shrink;
    logic scan_init;
    logic scan_step;
    logic rd_en;
    rd_sel_t rd_sel;
    logic latch_id;
    logic shift_wr;
    logic out_load;
    logic out_kind;
    logic out_last;
  } dtq_cmd_t;

  typedef struct packed {
    logic enable;
    logic scan_done;
    logic found;
    logic n_full;
    logic shift_done;
    logic out_free;
  } dtq_status_t;

endpackage

/* src/dtq_datapath.sv */
module dtq_datapath
  import dtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  dtq_cmd_t cmd,
  output dtq_status_t sts,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic [63:0] req_id,
  input  logic signed [31:0] timeout_ticks,
  output logic out_valid,
  input  logic out_stall,
  output logic kind,
  output logic [1:0] status,
  output logic [63:0] expired_id,
  output logic last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [63:0] dl_mem [CAPACITY];
  logic [63:0] id_mem [CAPACITY];

  logic enable;
  logic [63:0] now;
  logic [CNT_W-1:0] count;
  logic [63:0] in_id;
  logic [31:0] in_to;
  logic [63:0] rd_dl;
  logic [63:0] rd_id;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic rd_pend;
  logic found;
  logic [IDX_W-1:0] best_idx;
  logic [63:0] best_dl;
  logic [CNT_W-1:0] j;
  logic [OUT_CNT_W-1:0] n;
  logic [63:0] pend_id;

  logic [CNT_W-1:0] jn;
  logic [64:0] dl_sum;
  logic [63:0] dl_new;
  logic [IDX_W-1:0] rd_addr;
  logic [1:0] add_status;
  logic out_free;

  assign jn = j + CNT_W'(1);
  assign dl_sum = {1'b0, now} + {33'b0, in_to};
  assign dl_new = dl_sum[64] ? '1 : dl_sum[63:0];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN: rd_addr = idx[IDX_W-1:0];
      RD_BEST: rd_addr = best_idx;
      RD_NEXT: rd_addr = jn[IDX_W-1:0];
      default: rd_addr = idx[IDX_W-1:0];
    endcase
  end

  always_comb begin
    priority if (!enable) begin
      add_status = ST_DISABLED;
    end else if (in_to[31]) begin
      add_status = ST_NEGATIVE;
    end else if (count >= CNT_W'(CAPACITY)) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    sts.enable = enable;
    sts.scan_done = (idx == count) && !rd_pend;
    sts.found = found;
    sts.n_full = (n == OUT_CNT_W'(MAX_OUT));
    sts.shift_done = (jn >= count);
    sts.out_free = out_free;
  end

  // store
  always_ff @(posedge clk) begin
    if (cmd.add && add_status == ST_OK) begin
      dl_mem[count[IDX_W-1:0]] <= dl_new;
      id_mem[count[IDX_W-1:0]] <= in_id;
    end else if (cmd.shift_wr) begin
      dl_mem[j[IDX_W-1:0]] <= rd_dl;
      id_mem[j[IDX_W-1:0]] <= rd_id;
    end
    if (cmd.rd_en) begin
      rd_dl <= dl_mem[rd_addr];
      rd_id <= id_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_id <= req_id;
      in_to <= timeout_ticks;
    end
    if (cmd.latch_id) begin
      pend_id <= rd_id;
      j <= CNT_W'(best_idx);
    end else if (cmd.shift_wr) begin
      j <= jn;
    end
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      status <= (cmd.out_kind == KIND_ADD) ? add_status : ST_OK;
      expired_id <= (cmd.out_kind == KIND_ADD) ? 64'd0 : pend_id;
      last <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      now <= '0;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      rd_pend <= 1'b0;
      found <= 1'b0;
      n <= '0;
      best_idx <= '0;
      best_dl <= '0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
        if (cfg_wdata && !enable) begin
          count <= '0;
        end
      end
      if (cmd.tick) begin
        now <= now + 64'd1;
        n <= '0;
      end
      if (cmd.add && add_status == ST_OK) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.shrink) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.latch_id) begin
        n <= n + OUT_CNT_W'(1);
      end
      if (cmd.scan_init) begin
        idx <= '0;
        rd_pend <= 1'b0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        if (rd_pend && rd_dl <= now && (!found || rd_dl < best_dl)) begin
          found <= 1'b1;
          best_dl <= rd_dl;
          best_idx <= rd_idx;
        end
        if (idx < count) begin
          rd_pend <= 1'b1;
          rd_idx <= idx[IDX_W-1:0];
          idx <= idx + CNT_W'(1);
        end else begin
          rd_pend <= 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("pending count above capacity");
  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |-> count != '0) else $error("removal from empty store");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free) else $error("result overwritten");
  a_found_due: assert property (@(posedge clk) disable iff (rst)
    (found && !cmd.tick) |-> best_dl <= now) else $error("chosen entry not due");

endmodule

/* src/dtq_ctrl.sv */
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic mode,
  input  dtq_status_t sts,
  output dtq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_TICK,
    S_SCAN,
    S_DECIDE,
    S_TAKE,
    S_TAKE2,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SHRINK
  } state_t;

  state_t state;
  state_t state_next;
  logic have_pend;
  logic have_pend_next;
  logic accept;
  logic more;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign more = sts.found && !sts.n_full;

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_SCAN;
    state_next = state;
    have_pend_next = have_pend;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.tick = mode;
          state_next = mode ? S_TICK : S_ADD;
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.add = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ADD;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        cmd.scan_init = 1'b1;
        have_pend_next = 1'b0;
        state_next = sts.enable ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.rd_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!have_pend || sts.out_free) begin
          if (have_pend) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_EXPIRED;
            cmd.out_last = !more;
            have_pend_next = 1'b0;
          end
          state_next = more ? S_TAKE : S_IDLE;
        end
      end
      S_TAKE: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RD_BEST;
        state_next = S_TAKE2;
      end
      S_TAKE2: begin
        cmd.latch_id = 1'b1;
        have_pend_next = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (sts.shift_done) begin
          state_next = S_SHRINK;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_SHRINK: begin
        cmd.shrink = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have_pend <= 1'b0;
    end else begin
      state <= state_next;
      have_pend <= have_pend_next;
    end
  end

  a_pend_take: assert property (@(posedge clk) disable iff (rst)
    state == S_TAKE2 |=> have_pend) else $error("taken entry not held");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !have_pend) else $error("notice dropped");

endmodule

/* src/deadline_timeout_queue_core.sv */
// add: the request is captured, then its result is loaded once the output is free;
//   the next request is taken once the result is loaded. tick: time advances and,
//   when enabled, the store is scanned; per expired entry its id is read, each later
//   slot is moved down, the store shrinks, then a new scan; results wait while out_stall is high
// one result per expired entry, at most 16 per tick, the last one flagged
// synchronous reset clears time, enable, the pending count and the output valid flag
module deadline_timeout_queue_core
  import dtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic mode,
  input  logic [63:0] req_id,
  input  logic signed [31:0] timeout_ticks,
  output logic out_valid,
  input  logic out_stall,
  output logic kind,
  output logic [1:0] status,
  output logic [63:0] expired_id,
  output logic last
);

  dtq_cmd_t cmd;
  dtq_status_t sts;

  dtq_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .sts(sts),
    .cmd(cmd)
  );

  dtq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_id(req_id),
    .timeout_ticks(timeout_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .status(status),
    .expired_id(expired_id),
    .last(last)
  );

endmodule
